@@ hdl/assert_macros.svh @@
// Assertion macros shared by the order book RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, disabled while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on clk, disabled while arst_n is low.
`define ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

@@ hdl/lobm_pkg.sv @@
// Types, constants and codes of the limit order book matcher.
package lobm_pkg;

	localparam int PRICE_LEVELS = 256;
	localparam int ORDER_SLOTS  = 64;
	localparam int MAX_RESULTS  = 64;

	localparam int LVL_W  = $clog2(PRICE_LEVELS);
	localparam int SLOT_W = $clog2(ORDER_SLOTS);
	localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);
	localparam int RES_W  = $clog2(MAX_RESULTS + 1);
	localparam int RIDX_W = $clog2(MAX_RESULTS);

	// Best level search looks at one group of levels per cycle.
	localparam int GRP    = 16;
	localparam int NGRP   = PRICE_LEVELS / GRP;
	localparam int GRP_W  = $clog2(NGRP);
	localparam int GPOS_W = $clog2(GRP);

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_CANCEL = 2'd1;
	localparam logic [1:0] ACT_MODIFY = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] ord_id;
		logic        side;
		logic [31:0] price;
		logic [31:0] quantity;
	} lobm_in_t;

	typedef struct packed {
		logic        trade_valid;
		logic [31:0] buy_order_id;
		logic [31:0] sell_order_id;
		logic [31:0] trade_price;
		logic [31:0] trade_quantity;
		logic [1:0]  status;
		logic [31:0] best_bid;
		logic [31:0] best_ask;
		logic        last;
	} lobm_out_t;

	typedef struct packed {
		logic [31:0] buy_id;
		logic [31:0] sell_id;
		logic [31:0] price;
		logic [31:0] qty;
	} trade_t;

	typedef struct packed {
		logic [SLOT_W-1:0] head;
		logic [SLOT_W-1:0] tail;
		logic [CNT_W-1:0]  count;
	} lvl_ent_t;

	typedef struct packed {
		logic start;
		logic side;
	} scan_req_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [LVL_W-1:0] idx;
	} scan_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_M_SCAN, ST_M_SCANW, ST_L_RD, ST_L_USE, ST_S_RD, ST_FILL,
		ST_PLACE, ST_P_RD, ST_P_WR, ST_P_LNK, ST_F_RD, ST_F_CHK, ST_U_RD,
		ST_U_WR, ST_U_LNK, ST_FIN_B, ST_FIN_BW, ST_FIN_A, ST_FIN_AW,
		ST_O_RD, ST_O_LD
	} state_t;

endpackage

@@ hdl/limit_order_book_matcher.sv @@
// Limit order book matcher with price-time priority: a request of add, cancel
// or modify gives one result transfer per fill, or a single one if nothing
// fills, all carrying the best bid and best ask after the whole request. Orders
// rest in a 64-entry slot memory linked into per-level queues; level heads,
// tails and counts lie in a level memory, and one flip-flop per level marks it
// occupied. An add searches for the best opposite level before each fill (one
// group of 16 levels a cycle), then rests what is left where it can. Cancel
// and modify search the slot memory for the id one slot after another, up to
// all 64 slots. Every request ends with two best-level searches, bid then ask,
// and then reads out its result transfers. One request is worked at a time; the
// next may be taken while the last result still waits in the output register.
// No clearing pass is needed after reset.
`include "assert_macros.svh"

module limit_order_book_matcher import lobm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  lobm_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output lobm_out_t out_data,
	input  logic      cfg_we,
	input  logic [31:0] cfg_wdata
);

	state_t state_q, state_d;

	lobm_in_t          req_q;
	logic [31:0]       qty_q;
	logic [RES_W-1:0]  n_q;
	logic [RES_W-1:0]  r_q;
	logic [1:0]        status_q;
	logic [31:0]       price_hit_q;
	logic [SLOT_W-1:0] k_q;
	logic [SLOT_W-1:0] tail_q;
	logic [31:0]       bb_q;
	logic [31:0]       ba_q;
	logic [31:0]       base_q;
	lobm_out_t         out_q;
	logic              out_valid_q;

	logic [ORDER_SLOTS-1:0]  used_q;
	logic [PRICE_LEVELS-1:0] bid_map_q;
	logic [PRICE_LEVELS-1:0] ask_map_q;

	logic [LVL_W:0]    lvl_addr_q;
	logic [SLOT_W-1:0] slot_addr_q;

	// Level memory, indexed by side and level.
	lvl_ent_t lvl_mem [2*PRICE_LEVELS];
	lvl_ent_t lvl_rd;
	logic     lvl_we;
	lvl_ent_t lvl_wd;

	// Slot memories, one per field, sharing one write address.
	logic [31:0]       slot_id_mem   [ORDER_SLOTS];
	logic              slot_side_mem [ORDER_SLOTS];
	logic [LVL_W-1:0]  slot_lvl_mem  [ORDER_SLOTS];
	logic [31:0]       slot_qty_mem  [ORDER_SLOTS];
	logic [SLOT_W-1:0] slot_next_mem [ORDER_SLOTS];
	logic [SLOT_W-1:0] slot_prev_mem [ORDER_SLOTS];
	logic [31:0]       slot_id_rd;
	logic              slot_side_rd;
	logic [LVL_W-1:0]  slot_lvl_rd;
	logic [31:0]       slot_qty_rd;
	logic [SLOT_W-1:0] slot_next_rd;
	logic [SLOT_W-1:0] slot_prev_rd;

	logic [SLOT_W-1:0] sw_addr;
	logic              we_new, we_qty, we_next, we_prev;
	logic [31:0]       wd_qty;
	logic [SLOT_W-1:0] wd_next, wd_prev;

	logic   buf_we;
	trade_t buf_wd;
	trade_t buf_rd;

	scan_req_t scan_req;
	scan_rsp_t scan_rsp;

	logic              map_set, map_clr, used_set, used_clr;
	logic              accept, out_free, load_out;
	logic [31:0]       scan_price;
	logic              cross_ok;
	logic              lvl_bit;
	logic [CNT_W-1:0]  lvl_cnt;
	logic [31:0]       tq;
	logic [32:0]       off;
	logic              in_range;
	logic              free_any;
	logic [SLOT_W-1:0] free_k;
	logic              id_hit;
	logic              k_is_head, k_is_tail;
	logic [RES_W-1:0]  res_cnt;
	logic              res_last;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Shared datapath terms.
	always_comb begin
		scan_price = base_q + 32'(scan_rsp.idx);
		cross_ok   = req_q.side ? !(req_q.price > scan_price) : !(req_q.price < scan_price);
		lvl_bit    = lvl_addr_q[LVL_W] ? ask_map_q[lvl_addr_q[LVL_W-1:0]]
		                               : bid_map_q[lvl_addr_q[LVL_W-1:0]];
		lvl_cnt    = lvl_bit ? lvl_rd.count : '0;
		tq         = (qty_q < slot_qty_rd) ? qty_q : slot_qty_rd;
		off        = {1'b0, req_q.price} - {1'b0, base_q};
		in_range   = !off[32] && (off[31:0] < 32'(PRICE_LEVELS));
		id_hit     = used_q[slot_addr_q] && (slot_id_rd == req_q.ord_id);
		k_is_head  = (lvl_rd.head == slot_addr_q);
		k_is_tail  = (lvl_rd.tail == slot_addr_q);
		res_cnt    = (n_q == '0) ? RES_W'(1) : n_q;
		res_last   = (r_q == res_cnt - 1'b1);
	end

	// Lowest free slot.
	always_comb begin
		free_any = !(&used_q);
		free_k   = '0;
		for (int j = ORDER_SLOTS - 1; j >= 0; j--) begin
			if (!used_q[j]) free_k = SLOT_W'(j);
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and memory write controls.
	always_comb begin
		state_d  = state_q;
		lvl_we   = 1'b0;
		lvl_wd   = lvl_rd;
		sw_addr  = slot_addr_q;
		we_new   = 1'b0;
		we_qty   = 1'b0;
		we_next  = 1'b0;
		we_prev  = 1'b0;
		wd_qty   = req_q.quantity;
		wd_next  = slot_next_rd;
		wd_prev  = slot_prev_rd;
		buf_we   = 1'b0;
		buf_wd.buy_id  = req_q.side ? slot_id_rd : req_q.ord_id;
		buf_wd.sell_id = req_q.side ? req_q.ord_id : slot_id_rd;
		buf_wd.price   = price_hit_q;
		buf_wd.qty     = tq;
		scan_req.start = 1'b0;
		scan_req.side  = ~req_q.side;
		map_set  = 1'b0;
		map_clr  = 1'b0;
		used_set = 1'b0;
		used_clr = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_data.action)
						ACT_ADD: state_d = (in_data.quantity == '0) ? ST_FIN_B : ST_M_SCAN;
						ACT_CANCEL, ACT_MODIFY: state_d = ST_F_RD;
						default: state_d = ST_FIN_B;
					endcase
				end
			end
			ST_M_SCAN: begin
				if (n_q == RES_W'(MAX_RESULTS)) begin
					state_d = ST_PLACE;
				end else begin
					scan_req.start = 1'b1;
					state_d = ST_M_SCANW;
				end
			end
			ST_M_SCANW: begin
				if (scan_rsp.done) begin
					state_d = (scan_rsp.found && cross_ok) ? ST_L_RD : ST_PLACE;
				end
			end
			ST_L_RD: state_d = ST_L_USE;
			ST_L_USE: state_d = ST_S_RD;
			ST_S_RD: state_d = ST_FILL;
			ST_FILL: begin
				// Record the fill and take it off the resting order.
				buf_we = 1'b1;
				if (tq == slot_qty_rd) begin
					lvl_we       = 1'b1;
					lvl_wd.head  = slot_next_rd;
					lvl_wd.count = lvl_cnt - 1'b1;
					map_clr      = (lvl_cnt == CNT_W'(1));
					used_clr     = 1'b1;
				end else begin
					we_qty = 1'b1;
					wd_qty = slot_qty_rd - tq;
				end
				state_d = ((qty_q != tq) && (n_q != RES_W'(MAX_RESULTS - 1))) ?
				          ST_M_SCAN : ST_PLACE;
			end
			ST_PLACE: begin
				if (qty_q == '0 || !in_range || !free_any) state_d = ST_FIN_B;
				else state_d = ST_P_RD;
			end
			ST_P_RD: state_d = ST_P_WR;
			ST_P_WR: begin
				// Rest the remainder at the tail of its level.
				sw_addr  = k_q;
				we_new   = 1'b1;
				we_qty   = 1'b1;
				wd_qty   = qty_q;
				we_prev  = 1'b1;
				wd_prev  = lvl_rd.tail;
				used_set = 1'b1;
				lvl_we   = 1'b1;
				lvl_wd.head  = (lvl_cnt == '0) ? k_q : lvl_rd.head;
				lvl_wd.tail  = k_q;
				lvl_wd.count = lvl_cnt + 1'b1;
				map_set  = 1'b1;
				state_d  = (lvl_cnt != '0) ? ST_P_LNK : ST_FIN_B;
			end
			ST_P_LNK: begin
				sw_addr = tail_q;
				we_next = 1'b1;
				wd_next = k_q;
				state_d = ST_FIN_B;
			end
			ST_F_RD: state_d = ST_F_CHK;
			ST_F_CHK: begin
				if (id_hit) begin
					if (req_q.action == ACT_CANCEL || req_q.quantity == '0) begin
						state_d = ST_U_RD;
					end else begin
						we_qty  = 1'b1;
						state_d = ST_FIN_B;
					end
				end else if (slot_addr_q == SLOT_W'(ORDER_SLOTS - 1)) begin
					state_d = ST_FIN_B;
				end else begin
					state_d = ST_F_RD;
				end
			end
			ST_U_RD: state_d = ST_U_WR;
			ST_U_WR: begin
				// Unlink the slot from its queue and free it.
				lvl_we       = 1'b1;
				lvl_wd.head  = k_is_head ? slot_next_rd : lvl_rd.head;
				lvl_wd.tail  = (!k_is_head && k_is_tail) ? slot_prev_rd : lvl_rd.tail;
				lvl_wd.count = lvl_cnt - 1'b1;
				map_clr      = (lvl_cnt == CNT_W'(1));
				used_clr     = 1'b1;
				if (!k_is_head) begin
					sw_addr = slot_prev_rd;
					we_next = 1'b1;
					wd_next = slot_next_rd;
				end
				state_d = (!k_is_head && !k_is_tail) ? ST_U_LNK : ST_FIN_B;
			end
			ST_U_LNK: begin
				sw_addr = slot_next_rd;
				we_prev = 1'b1;
				wd_prev = slot_prev_rd;
				state_d = ST_FIN_B;
			end
			ST_FIN_B: begin
				scan_req.start = 1'b1;
				scan_req.side  = 1'b0;
				state_d = ST_FIN_BW;
			end
			ST_FIN_BW: if (scan_rsp.done) state_d = ST_FIN_A;
			ST_FIN_A: begin
				scan_req.start = 1'b1;
				scan_req.side  = 1'b1;
				state_d = ST_FIN_AW;
			end
			ST_FIN_AW: if (scan_rsp.done) state_d = ST_O_RD;
			ST_O_RD: state_d = ST_O_LD;
			ST_O_LD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = res_last ? ST_IDLE : ST_O_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Request datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q       <= in_data;
					qty_q       <= in_data.quantity;
					n_q         <= '0;
					status_q    <= STAT_OK;
					slot_addr_q <= '0;
				end
			end
			ST_M_SCANW: begin
				price_hit_q <= scan_price;
				lvl_addr_q  <= {~req_q.side, scan_rsp.idx};
			end
			ST_L_USE: slot_addr_q <= lvl_rd.head;
			ST_FILL: begin
				qty_q <= qty_q - tq;
				n_q   <= n_q + 1'b1;
			end
			ST_PLACE: begin
				if (qty_q != '0) begin
					if (!in_range) status_q <= STAT_MISS;
					else if (!free_any) status_q <= STAT_FULL;
					k_q        <= free_k;
					lvl_addr_q <= {req_q.side, off[LVL_W-1:0]};
				end
			end
			ST_P_WR: tail_q <= lvl_rd.tail;
			ST_F_CHK: begin
				if (id_hit) lvl_addr_q <= {slot_side_rd, slot_lvl_rd};
				else if (slot_addr_q == SLOT_W'(ORDER_SLOTS - 1)) status_q <= STAT_MISS;
				else slot_addr_q <= slot_addr_q + 1'b1;
			end
			ST_FIN_BW: if (scan_rsp.done) bb_q <= scan_rsp.found ? scan_price : '0;
			ST_FIN_AW: begin
				if (scan_rsp.done) begin
					ba_q <= scan_rsp.found ? scan_price : '1;
					r_q  <= '0;
				end
			end
			ST_O_LD: if (load_out) r_q <= r_q + 1'b1;
			default: ;
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= '0;
		else if (cfg_we) base_q <= cfg_wdata;
	end

	// Slot occupancy and occupied-level maps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			bid_map_q <= '0;
			ask_map_q <= '0;
		end else begin
			if (used_set) used_q[k_q] <= 1'b1;
			if (used_clr) used_q[slot_addr_q] <= 1'b0;
			if (map_set || map_clr) begin
				if (lvl_addr_q[LVL_W]) ask_map_q[lvl_addr_q[LVL_W-1:0]] <= map_set;
				else bid_map_q[lvl_addr_q[LVL_W-1:0]] <= map_set;
			end
		end
	end

	// Level memory.
	always_ff @(posedge clk) begin
		if (lvl_we) lvl_mem[lvl_addr_q] <= lvl_wd;
		lvl_rd <= lvl_mem[lvl_addr_q];
	end

	// Slot memories.
	always_ff @(posedge clk) begin
		if (we_new) begin
			slot_id_mem[sw_addr]   <= req_q.ord_id;
			slot_side_mem[sw_addr] <= req_q.side;
			slot_lvl_mem[sw_addr]  <= lvl_addr_q[LVL_W-1:0];
		end
		if (we_qty) slot_qty_mem[sw_addr] <= wd_qty;
		if (we_next) slot_next_mem[sw_addr] <= wd_next;
		if (we_prev) slot_prev_mem[sw_addr] <= wd_prev;
		slot_id_rd   <= slot_id_mem[slot_addr_q];
		slot_side_rd <= slot_side_mem[slot_addr_q];
		slot_lvl_rd  <= slot_lvl_mem[slot_addr_q];
		slot_qty_rd  <= slot_qty_mem[slot_addr_q];
		slot_next_rd <= slot_next_mem[slot_addr_q];
		slot_prev_rd <= slot_prev_mem[slot_addr_q];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.trade_valid    <= (n_q != '0);
			out_q.buy_order_id   <= (n_q != '0) ? buf_rd.buy_id : '0;
			out_q.sell_order_id  <= (n_q != '0) ? buf_rd.sell_id : '0;
			out_q.trade_price    <= (n_q != '0) ? buf_rd.price : '0;
			out_q.trade_quantity <= (n_q != '0) ? buf_rd.qty : '0;
			out_q.status         <= res_last ? status_q : STAT_OK;
			out_q.best_bid       <= bb_q;
			out_q.best_ask       <= ba_q;
			out_q.last           <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	lobm_best_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (scan_req),
		.bid_map (bid_map_q),
		.ask_map (ask_map_q),
		.rsp     (scan_rsp)
	);

	lobm_result_buf u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (n_q[RIDX_W-1:0]),
		.wdata (buf_wd),
		.raddr (r_q[RIDX_W-1:0]),
		.rdata (buf_rd)
	);

	// The fill count never passes the result limit while a request is worked.
	`ASSERT_CLK(a_n_limit, (state_q == ST_IDLE) || (n_q <= RES_W'(MAX_RESULTS)), "fill count beyond result limit")
	// A fill always hits an occupied level.
	`ASSERT_IMPL(a_fill_level, state_q == ST_FILL, lvl_bit, "fill on an empty level")
	// A new order is only placed in a free slot.
	`ASSERT_IMPL(a_place_free, state_q == ST_P_WR, !used_q[k_q], "order placed in a used slot")

endmodule

@@ hdl/lobm_best_scan.sv @@
// Search of the occupied-level map for the best bid or best ask level.
module lobm_best_scan import lobm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  scan_req_t               req,
	input  logic [PRICE_LEVELS-1:0] bid_map,
	input  logic [PRICE_LEVELS-1:0] ask_map,
	output scan_rsp_t               rsp
);

	logic              busy_q;
	logic              side_q;
	logic [GRP_W-1:0]  grp_q;
	logic [GRP_W-1:0]  grp;
	logic [GRP-1:0]    bits;
	logic [GPOS_W-1:0] pos;
	logic              any;

	// Asks are searched upwards from level zero, bids downwards from the top.
	always_comb begin
		grp  = side_q ? grp_q : (GRP_W'(NGRP - 1) - grp_q);
		bits = side_q ? ask_map[{grp, {GPOS_W{1'b0}}} +: GRP]
		              : bid_map[{grp, {GPOS_W{1'b0}}} +: GRP];
		any  = |bits;
		pos  = '0;
		for (int j = 0; j < GRP; j++) begin
			if (side_q) begin
				if (bits[GRP-1-j]) pos = GPOS_W'(GRP - 1 - j);
			end else begin
				if (bits[j]) pos = GPOS_W'(j);
			end
		end
		rsp.done  = busy_q && (any || grp_q == GRP_W'(NGRP - 1));
		rsp.found = any;
		rsp.idx   = {grp, pos};
	end

	// One group per cycle until a level is found or the map is exhausted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			side_q <= 1'b0;
			grp_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			side_q <= req.side;
			grp_q  <= '0;
		end else if (busy_q) begin
			if (rsp.done) busy_q <= 1'b0;
			else grp_q <= grp_q + 1'b1;
		end
	end

endmodule

@@ hdl/lobm_result_buf.sv @@
// Buffer that holds the fills of one request until the best prices are known.
module lobm_result_buf import lobm_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [RIDX_W-1:0] waddr,
	input  trade_t            wdata,
	input  logic [RIDX_W-1:0] raddr,
	output trade_t            rdata
);

	trade_t mem [MAX_RESULTS];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ test/tb.sv @@
// Self-checking testbench of the limit order book matcher, with its scoreboard and predictor.
`timescale 1ns / 1ps

module tb import lobm_pkg::*; ();

	// Predicts the results of each accepted request and checks the result transfers against them.
	class book_scoreboard;
		bit [31:0] base_price;
		bit [31:0] slot_id [ORDER_SLOTS];
		bit        slot_side [ORDER_SLOTS];
		int        slot_level [ORDER_SLOTS];
		bit [31:0] slot_qty [ORDER_SLOTS];
		int        slot_next [ORDER_SLOTS];
		bit        slot_used [ORDER_SLOTS];
		int        lvl_head [2][PRICE_LEVELS];
		int        lvl_tail [2][PRICE_LEVELS];
		bit [31:0] lvl_total [2][PRICE_LEVELS];
		int        lvl_count [2][PRICE_LEVELS];
		lobm_out_t expected_results [$];
		int        mismatches;

		function new();
			base_price = '0;
			mismatches = 0;
			foreach (slot_used[k]) slot_used[k] = 0;
			for (int s = 0; s < 2; s++) begin
				for (int l = 0; l < PRICE_LEVELS; l++) begin
					lvl_count[s][l] = 0;
					lvl_total[s][l] = '0;
					lvl_head[s][l] = 0;
					lvl_tail[s][l] = 0;
				end
			end
		endfunction

		// Best level: highest index for bids, lowest for asks.
		function bit best_level(bit s, output int idx);
			idx = 0;
			if (s) begin
				for (int i = 0; i < PRICE_LEVELS; i++)
					if (lvl_count[s][i] != 0) begin
						idx = i;
						return 1;
					end
			end else begin
				for (int i = PRICE_LEVELS - 1; i >= 0; i--)
					if (lvl_count[s][i] != 0) begin
						idx = i;
						return 1;
					end
			end
			return 0;
		endfunction

		// Takes a slot out of its level queue and frees it.
		function void remove_order(int k);
			bit s;
			int l, p;
			s = slot_side[k];
			l = slot_level[k];
			if (lvl_head[s][l] == k) begin
				lvl_head[s][l] = slot_next[k];
			end else begin
				p = lvl_head[s][l];
				for (int i = 0; i < ORDER_SLOTS; i++) begin
					if (slot_next[p] == k) begin
						slot_next[p] = slot_next[k];
						if (lvl_tail[s][l] == k) lvl_tail[s][l] = p;
						break;
					end
					p = slot_next[p];
				end
			end
			lvl_total[s][l] -= slot_qty[k];
			if (lvl_count[s][l] != 0) lvl_count[s][l]--;
			if (lvl_count[s][l] == 0) lvl_total[s][l] = '0;
			slot_used[k] = 0;
		endfunction

		// Notes an accepted request and queues the results that it must give.
		function void note_request(lobm_in_t rq);
			lobm_out_t res [$];
			lobm_out_t r;
			bit [31:0] qty, p, tq, bb, ba;
			bit [1:0]  st;
			bit        opp;
			int        idx, k, l;
			qty = rq.quantity;
			st = STAT_OK;
			if (rq.action == ACT_ADD) begin
				opp = ~rq.side;
				// Match against the opposite side, one fill per transfer.
				while (qty != 0 && res.size() < MAX_RESULTS && best_level(opp, idx)) begin
					p = base_price + idx;
					if (rq.side == 1'b0 ? (rq.price < p) : (rq.price > p)) break;
					k = lvl_head[opp][idx];
					tq = (qty < slot_qty[k]) ? qty : slot_qty[k];
					r = '0;
					r.trade_valid = 1'b1;
					r.buy_order_id = rq.side ? slot_id[k] : rq.ord_id;
					r.sell_order_id = rq.side ? rq.ord_id : slot_id[k];
					r.trade_price = p;
					r.trade_quantity = tq;
					res = {res, r};
					slot_qty[k] -= tq;
					qty -= tq;
					lvl_total[opp][idx] -= tq;
					if (slot_qty[k] == 0) remove_order(k);
				end
				// Rest what is left at the tail of its level.
				if (qty != 0) begin
					if (rq.price < base_price || (rq.price - base_price) >= PRICE_LEVELS) begin
						st = STAT_MISS;
					end else begin
						k = 0;
						while (k < ORDER_SLOTS && slot_used[k]) k++;
						if (k == ORDER_SLOTS) begin
							st = STAT_FULL;
						end else begin
							l = int'(rq.price - base_price);
							slot_id[k] = rq.ord_id;
							slot_side[k] = rq.side;
							slot_level[k] = l;
							slot_qty[k] = qty;
							slot_next[k] = 0;
							slot_used[k] = 1;
							if (lvl_count[rq.side][l] == 0) lvl_head[rq.side][l] = k;
							else slot_next[lvl_tail[rq.side][l]] = k;
							lvl_tail[rq.side][l] = k;
							lvl_count[rq.side][l]++;
							lvl_total[rq.side][l] += qty;
						end
					end
				end
			end else if (rq.action == ACT_CANCEL || rq.action == ACT_MODIFY) begin
				k = -1;
				for (int i = 0; i < ORDER_SLOTS; i++)
					if (slot_used[i] && slot_id[i] == rq.ord_id) begin
						k = i;
						break;
					end
				if (k < 0) begin
					st = STAT_MISS;
				end else if (rq.action == ACT_CANCEL || rq.quantity == 0) begin
					remove_order(k);
				end else begin
					l = slot_level[k];
					lvl_total[slot_side[k]][l] = lvl_total[slot_side[k]][l] - slot_qty[k]
						+ rq.quantity;
					slot_qty[k] = rq.quantity;
				end
			end
			if (res.size() == 0) begin
				r = '0;
				res = {res, r};
			end
			bb = '0;
			ba = '1;
			if (best_level(1'b0, idx)) bb = base_price + idx;
			if (best_level(1'b1, idx)) ba = base_price + idx;
			foreach (res[i]) begin
				res[i].best_bid = bb;
				res[i].best_ask = ba;
				res[i].last = (i == res.size() - 1);
				if (i == res.size() - 1) res[i].status = st;
				expected_results = {expected_results, res[i]};
			end
		endfunction

		// Compares one result transfer with the oldest expectation.
		function void check_result(lobm_out_t got);
			lobm_out_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			want = expected_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch\n  expected %p\n  actual   %p", want, got);
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	lobm_in_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	lobm_out_t out_data;
	logic      cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	book_scoreboard book = new();
	int        idle_pct = 0;
	int        stall_pct = 0;
	int        hold_cycles = 0;
	bit        hold_request = 0;
	bit [31:0] next_id = 32'd100;
	bit [31:0] live_ids [$];

	limit_order_book_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: checks each transfer and stalls at random or for a long hold.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) book.check_result(out_data);
		if (hold_request) begin
			hold_request = 0;
			hold_cycles = 400;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offers one request, with random idle cycles first, and waits until it is accepted.
	task automatic put_request(lobm_in_t rq);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= rq;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		book.note_request(rq);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (book.expected_results.size() != 0) @(posedge clk);
	endtask

	// Changes the base price once the book is idle.
	task automatic write_base(bit [31:0] value);
		drain_results();
		repeat (60) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.base_price = value;
	endtask

	function automatic lobm_in_t make_req(bit [1:0] act, bit [31:0] id, bit sd,
			bit [31:0] px, bit [31:0] q);
		lobm_in_t rq;
		rq.action = act;
		rq.ord_id = id;
		rq.side = sd;
		rq.price = px;
		rq.quantity = q;
		return rq;
	endfunction

	// Mostly a well-formed book flow around the base price, with some noise.
	function automatic lobm_in_t random_request(bit [31:0] base);
		lobm_in_t rq;
		int pick, q;
		rq = make_req(ACT_ADD, next_id, $urandom_range(1), '0, '0);
		pick = $urandom_range(99);
		if (pick < 58) begin
			next_id++;
			if ($urandom_range(9) == 0) rq.ord_id = $urandom;
			if ($urandom_range(19) == 0 && live_ids.size() != 0)
				rq.ord_id = live_ids[$urandom_range(live_ids.size() - 1)];
			live_ids = {live_ids, rq.ord_id};
			q = $urandom_range(99);
			if (q < 8) rq.price = $urandom;
			else if (q < 14) rq.price = rq.side ? base : base + 255;
			else if (q < 18) rq.price = rq.side ? base - 1 : base + 256;
			else rq.price = base + (rq.side ? $urandom_range(100, 255) : $urandom_range(0, 140));
			q = $urandom_range(99);
			if (q < 4) rq.quantity = '0;
			else if (q < 9) rq.quantity = $urandom;
			else if (q < 12) rq.quantity = '1;
			else rq.quantity = $urandom_range(1, 60);
		end else if (pick < 90) begin
			rq.action = (pick < 76) ? ACT_CANCEL : ACT_MODIFY;
			rq.side = $urandom_range(1);
			rq.price = $urandom;
			rq.quantity = ($urandom_range(4) == 0) ? '0 : $urandom_range(1, 80);
			if ($urandom_range(7) == 0) rq.quantity = $urandom;
			if (live_ids.size() != 0 && $urandom_range(5) != 0)
				rq.ord_id = live_ids[$urandom_range(live_ids.size() - 1)];
			else
				rq.ord_id = $urandom;
		end else begin
			rq = make_req(2'd3, $urandom, $urandom_range(1), $urandom, $urandom);
		end
		return rq;
	endfunction

	initial begin
		bit [31:0] bases [4];
		bases = '{32'd1000, 32'h7FFF_FFF0, 32'hFFFF_FF00, 32'hFFFF_FFFF};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset base price of zero.
		put_request(make_req(ACT_ADD, 32'd1, 1'b0, 32'd10, 32'd5));
		put_request(make_req(ACT_ADD, 32'd2, 1'b1, 32'd12, 32'd3));
		put_request(make_req(ACT_ADD, 32'd3, 1'b1, 32'd9, 32'd8));
		put_request(make_req(ACT_ADD, 32'd4, 1'b0, 32'd0, 32'd2));
		put_request(make_req(ACT_ADD, 32'd5, 1'b1, 32'd0, 32'd1));
		put_request(make_req(ACT_CANCEL, 32'd2, 1'b0, '0, '0));
		put_request(make_req(ACT_MODIFY, 32'd3, 1'b1, '0, 32'd7));
		put_request(make_req(ACT_MODIFY, 32'd3, 1'b0, '0, '0));
		put_request(make_req(ACT_CANCEL, '1, 1'b1, '1, '1));
		put_request(make_req(ACT_MODIFY, 32'h5555_AAAA, 1'b0, '0, 32'd4));
		put_request(make_req(ACT_ADD, 32'd6, 1'b0, 32'd50, '0));
		put_request(make_req(2'd3, '1, 1'b1, '1, '1));
		put_request(make_req(ACT_ADD, 32'd8, 1'b0, 32'd256, 32'd1));
		put_request(make_req(ACT_ADD, '1, 1'b1, '1, '1));
		put_request(make_req(ACT_ADD, '0, 1'b0, 32'd255, '1));
		put_request(make_req(ACT_ADD, 32'd7, 1'b0, 32'd5, 32'd1));
		put_request(make_req(ACT_ADD, 32'd7, 1'b0, 32'd5, 32'd2));
		put_request(make_req(ACT_CANCEL, 32'd7, 1'b0, '0, '0));
		put_request(make_req(ACT_ADD, 32'd9, 1'b1, 32'd200, '1));
		put_request(make_req(ACT_ADD, 32'd10, 1'b1, 32'd1, 32'd3));
		put_request(make_req(ACT_ADD, 32'd11, 1'b0, '1, 32'd2));

		// Random phases, each under a new base price and a new idling pattern.
		for (int ph = 0; ph < 4; ph++) begin
			write_base(bases[ph]);
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 62;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 62;
				end
				default: begin
					idle_pct = 22;
					stall_pct = 22;
				end
			endcase
			if (ph == 1) begin
				// Long hold on the result side while requests keep coming.
				idle_pct = 0;
				hold_request = 1;
				repeat (8) put_request(random_request(bases[ph]));
				idle_pct = 62;
			end
			repeat (24) put_request(random_request(bases[ph]));
		end
		write_base('0);
		repeat (6) put_request(random_request('0));

		drain_results();
		repeat (200) @(posedge clk);
		if (book.mismatches == 0 && book.expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
